/* sv/assert_macros.svh */
// Assertion helpers for the mouse packet decoder, clocked on clk, disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PMD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pmd: property failed");
`define PMD_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("pmd: forbidden condition seen");
`else
`define PMD_ASSERT(label, prop)
`define PMD_ASSERT_NEVER(label, expr)
`endif
`endif

/* sv/pmd_pkg.sv */
package pmd_pkg;

	localparam int CFG_W        = 13;
	localparam int RESET_WIDTH  = 1024;
	localparam int RESET_HEIGHT = 768;
	localparam int Q_DEPTH      = 4;
	localparam int EV_CNT       = 5;

	typedef enum logic [1:0] {
		EV_MOVE  = 2'd0,
		EV_DOWN  = 2'd1,
		EV_UP    = 2'd2,
		EV_WHEEL = 2'd3
	} event_kind_t;

	typedef enum logic [1:0] {
		REG_WHEEL_MODE    = 2'd0,
		REG_SCREEN_WIDTH  = 2'd1,
		REG_SCREEN_HEIGHT = 2'd2
	} reg_index_t;

	// one decoded packet; dx/dy are the raw 9-bit two's complement deltas,
	// wheel is already negated
	typedef struct packed {
		logic [2:0] buttons;
		logic [8:0] dx;
		logic [8:0] dy;
		logic [4:0] wheel;
	} pkt_t;

endpackage

/* sv/pmd_front.sv */
module pmd_front import pmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic             q_full,
	output logic             q_push,
	output pkt_t             q_data
);

	logic       wheel_mode_q;
	logic [1:0] pos_q;
	logic [7:0] held_q [3];

	logic       accept;
	logic       drop;
	logic       complete;
	logic [1:0] last_pos;
	logic [7:0] flags;
	logic [7:0] pkt2;
	logic [3:0] nib;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign drop     = (pos_q == 2'd0) && !s_tdata[3];
	assign last_pos = wheel_mode_q ? 2'd3 : 2'd2;
	assign complete = pos_q >= last_pos;

	assign flags = held_q[0];
	assign pkt2  = (pos_q == 2'd2) ? s_tdata : held_q[2];
	assign nib   = s_tdata[3:0];

	always_comb begin
		q_data.buttons = flags[2:0];
		q_data.dx      = {flags[4], held_q[1]};
		q_data.dy      = {flags[5], pkt2};
		q_data.wheel   = wheel_mode_q ? (5'd0 - {nib[3], nib}) : 5'd0;
	end

	// overflow packets vanish here; only the byte count moves
	assign q_push = accept && !drop && complete && !(flags[7] || flags[6]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_mode_q <= 1'b0;
			pos_q        <= 2'd0;
		end else begin
			if (cfg_we && (cfg_index == REG_WHEEL_MODE))
				wheel_mode_q <= cfg_data[0];
			if (accept && !drop)
				pos_q <= complete ? 2'd0 : pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !drop && !complete) begin
			case (pos_q)
				2'd0: held_q[0] <= s_tdata;
				2'd1: held_q[1] <= s_tdata;
				2'd2: held_q[2] <= s_tdata;
				default: ;
			endcase
		end
	end

endmodule

/* sv/pmd_queue.sv */
module pmd_queue import pmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pkt_t din,
	output logic full,
	input  logic pop,
	output logic valid,
	output pkt_t dout
);

	localparam int AW = $clog2(Q_DEPTH);

	pkt_t          mem_q [Q_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign full  = cnt_q == (AW+1)'(Q_DEPTH);
	assign valid = cnt_q != '0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)
				rd_q <= (rd_q == AW'(Q_DEPTH - 1)) ? '0 : rd_q + AW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

endmodule

/* sv/pmd_back.sv */
module pmd_back import pmd_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  q_valid,
	input  pkt_t                  q_data,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output event_kind_t           ev_kind,
	output logic [COORD_BITS-1:0] ptr_x,
	output logic [COORD_BITS-1:0] ptr_y,
	output logic signed [8:0]     delta_x,
	output logic signed [9:0]     delta_y,
	output logic [2:0]            button_mask,
	output logic [2:0]            changed_button,
	output logic signed [4:0]     wheel_step,
	output logic                  last_of_run
);

	localparam int EW  = COORD_BITS + 1;
	localparam int CW  = (EW > CFG_W) ? EW : CFG_W;
	localparam int SW  = COORD_BITS + 2;
	localparam int LIM = 2 ** COORD_BITS;
	localparam int RST_WE = (RESET_WIDTH > LIM) ? LIM : RESET_WIDTH;
	localparam int RST_HE = (RESET_HEIGHT > LIM) ? LIM : RESET_HEIGHT;
	localparam logic [COORD_BITS-1:0] RST_XMAX = COORD_BITS'(RST_WE - 1);
	localparam logic [COORD_BITS-1:0] RST_YMAX = COORD_BITS'(RST_HE - 1);
	localparam logic [COORD_BITS-1:0] RST_X    = COORD_BITS'(RST_WE / 2);
	localparam logic [COORD_BITS-1:0] RST_Y    = COORD_BITS'(RST_HE / 2);

	function automatic logic [CW-1:0] eff_bound(input logic [CFG_W-1:0] b);
		logic [CW-1:0] be;
		logic [CW-1:0] lim;
		be  = CW'(b);
		lim = CW'(1) << COORD_BITS;
		if (b == '0)
			return CW'(1);
		else if (be > lim)
			return lim;
		else
			return be;
	endfunction

	// cursor state and bounds
	logic [COORD_BITS-1:0] px_q, py_q, xmax_q, ymax_q;
	logic [2:0]            btn_q;
	// packet being unrolled into events
	logic [EV_CNT-1:0]     pend_q;
	logic signed [8:0]     dx_q;
	logic signed [9:0]     ndy_q;
	logic signed [4:0]     wheel_q;
	// output register
	logic                  ovalid_q;
	event_kind_t           kind_q;
	logic [COORD_BITS-1:0] ox_q, oy_q;
	logic signed [8:0]     odx_q;
	logic signed [9:0]     ondy_q;
	logic [2:0]            obtn_q, ochg_q;
	logic signed [4:0]     owhl_q;
	logic                  olast_q;

	logic [CW-1:0]         eff_v, eff_m1, eff_half;
	logic signed [8:0]     dx_in, dy_in;
	logic signed [SW-1:0]  sx, sy;
	logic [COORD_BITS-1:0] nx, ny;
	logic [EV_CNT-1:0]     pick, rest, new_pend;
	logic                  load_ok, emit;
	event_kind_t           pick_kind;

	assign eff_v    = eff_bound(cfg_data);
	assign eff_m1   = eff_v - CW'(1);
	assign eff_half = eff_v >> 1;

	assign dx_in = $signed(q_data.dx);
	assign dy_in = $signed(q_data.dy);
	assign sx    = $signed({2'b00, px_q}) + SW'(dx_in);
	assign sy    = $signed({2'b00, py_q}) - SW'(dy_in);

	always_comb begin
		if (sx < 0)
			nx = '0;
		else if (sx > $signed({2'b00, xmax_q}))
			nx = xmax_q;
		else
			nx = sx[COORD_BITS-1:0];
		if (sy < 0)
			ny = '0;
		else if (sy > $signed({2'b00, ymax_q}))
			ny = ymax_q;
		else
			ny = sy[COORD_BITS-1:0];
	end

	// event order: move, left, right, middle, wheel
	assign new_pend = {q_data.wheel != 5'd0, q_data.buttons ^ btn_q,
		(q_data.dx != 9'd0) || (q_data.dy != 9'd0)};

	assign pick    = pend_q & (~pend_q + EV_CNT'(1));
	assign rest    = pend_q & ~pick;
	assign load_ok = !ovalid_q || m_tready;
	assign emit    = (pend_q != '0) && load_ok;
	assign q_pop   = q_valid && ((pend_q == '0) || (emit && (rest == '0)));

	always_comb begin
		if (pick[0])
			pick_kind = EV_MOVE;
		else if (pick[EV_CNT-1])
			pick_kind = EV_WHEEL;
		else if ((pick[3:1] & btn_q) != 3'd0)
			pick_kind = EV_DOWN;
		else
			pick_kind = EV_UP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q     <= RST_X;
			py_q     <= RST_Y;
			xmax_q   <= RST_XMAX;
			ymax_q   <= RST_YMAX;
			btn_q    <= 3'd0;
			pend_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				px_q   <= nx;
				py_q   <= ny;
				btn_q  <= q_data.buttons;
				pend_q <= new_pend;
			end else if (emit) begin
				pend_q <= rest;
			end
			if (emit)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
			// user must make bound writes only while idle (not enforced here); recentre on either axis,
			// half of (max + 1) taken as max/2 rounded up so a full bound cannot wrap
			if (cfg_we && (cfg_index == REG_SCREEN_WIDTH)) begin
				xmax_q <= eff_m1[COORD_BITS-1:0];
				px_q   <= eff_half[COORD_BITS-1:0];
				py_q   <= (ymax_q >> 1) + COORD_BITS'(ymax_q[0]);
			end
			if (cfg_we && (cfg_index == REG_SCREEN_HEIGHT)) begin
				ymax_q <= eff_m1[COORD_BITS-1:0];
				py_q   <= eff_half[COORD_BITS-1:0];
				px_q   <= (xmax_q >> 1) + COORD_BITS'(xmax_q[0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dx_q    <= dx_in;
			ndy_q   <= 10'sd0 - 10'(dy_in);
			wheel_q <= $signed(q_data.wheel);
		end
		if (emit) begin
			kind_q  <= pick_kind;
			ox_q    <= px_q;
			oy_q    <= py_q;
			odx_q   <= dx_q;
			ondy_q  <= ndy_q;
			obtn_q  <= btn_q;
			ochg_q  <= pick[3:1];
			owhl_q  <= pick[EV_CNT-1] ? wheel_q : 5'sd0;
			olast_q <= rest == '0;
		end
	end

	assign m_tvalid       = ovalid_q;
	assign ev_kind        = kind_q;
	assign ptr_x          = ox_q;
	assign ptr_y          = oy_q;
	assign delta_x        = odx_q;
	assign delta_y        = ondy_q;
	assign button_mask    = obtn_q;
	assign changed_button = ochg_q;
	assign wheel_step     = owhl_q;
	assign last_of_run    = olast_q;

endmodule

/* sv/ps2_mouse_packet_decoder.sv */
// PS/2 mouse packet decoder. Raw mouse bytes enter on the s_ side, one per cycle while
// s_tready is high; s_tready drops only when the four-packet queue between the byte
// assembler and the event generator is full. Each good packet leaves as zero to five
// events on the m_ side, one event per cycle while m_tready is high, tlast marking
// the last event of the packet, so sustained throughput is set by the event generator.
// A packet passes through the queue, the pending-event register and the output
// register before it shows on m_tvalid. Writes to the bound registers recentre the
// cursor and must only be made while the block is idle.
`include "assert_macros.svh"

module ps2_mouse_packet_decoder import pmd_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	// byte input
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // data_byte
	// event output
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// ptr_x, ptr_y, delta_x, delta_y, button_mask, changed_button, wheel_step
	output logic [((2*COORD_BITS+30+7)/8)*8-1:0] m_tdata,
	output logic [1:0]                m_tuser,   // event_kind
	output logic                      m_tlast    // last_of_run
);

	localparam int DW  = ((2*COORD_BITS + 30 + 7) / 8) * 8;
	localparam int PW  = 2*COORD_BITS + 30;

	logic                  q_full, q_push, q_pop, q_valid;
	pkt_t                  q_in, q_out;
	event_kind_t           ev_kind;
	logic [COORD_BITS-1:0] cx_w, cy_w;
	logic signed [8:0]     dx_w;
	logic signed [9:0]     dy_w;
	logic [2:0]            btn_w, chg_w;
	logic signed [4:0]     whl_w;
	logic                  ev_move_w, ev_btn_w, ev_wheel_w, btn_hit_w;

	pmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	pmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_out)
	);

	pmd_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.q_valid        (q_valid),
		.q_data         (q_out),
		.q_pop          (q_pop),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.ev_kind        (ev_kind),
		.ptr_x          (cx_w),
		.ptr_y          (cy_w),
		.delta_x        (dx_w),
		.delta_y        (dy_w),
		.button_mask    (btn_w),
		.changed_button (chg_w),
		.wheel_step     (whl_w),
		.last_of_run    (m_tlast)
	);

	assign m_tdata = {(DW-PW)'(0), whl_w, chg_w, btn_w, dy_w, dx_w, cy_w, cx_w};
	assign m_tuser = ev_kind;

	assign ev_move_w  = m_tvalid && (ev_kind == EV_MOVE);
	assign ev_btn_w   = m_tvalid && (ev_kind == EV_DOWN || ev_kind == EV_UP);
	assign ev_wheel_w = m_tvalid && (ev_kind == EV_WHEEL);
	assign btn_hit_w  = (chg_w & btn_w) != 3'd0;

	`PMD_ASSERT(a_move_clean, ev_move_w |-> (chg_w == 3'd0) && (whl_w == 5'sd0))
	`PMD_ASSERT(a_button_event, ev_btn_w |-> $onehot(chg_w) && (btn_hit_w == (ev_kind == EV_DOWN)))
	`PMD_ASSERT_NEVER(a_wheel_nonzero, ev_wheel_w && (whl_w == 5'sd0))
	`PMD_ASSERT(a_run_continues, m_tvalid && m_tready && !m_tlast |=> m_tvalid)

endmodule
